[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Shared assertion forms. Each one expects clk and arst_n in the module that uses it.

// Same-cycle implication.
`define AFD_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AFD_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/afd_pkg.sv]
package afd_pkg;

	localparam int MAX_CHANNELS = 8;
	localparam int CH_W         = 3;
	localparam int CH_CNT_W     = 4;
	localparam int SAMPLE_W     = 24;
	localparam int STATUS_W     = 32;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;

	localparam logic [2:0]  WB_16 = 3'd2;
	localparam logic [2:0]  WB_24 = 3'd3;
	localparam logic [2:0]  WB_32 = 3'd4;

	localparam logic [2:0]  WORD_SIZE_RESET = 3'd3;
	localparam logic [3:0]  CHANNELS_RESET  = 4'd8;
	localparam logic        CRC_EN_RESET    = 1'b0;
	localparam logic [23:0] SPIKE_THR_RESET = 24'd2936012;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [7:0]  HDR_MARK = 8'h05;
	localparam logic [5:0]  POS_MAX  = 6'd63;
	localparam logic [1:0]  GOOD_FILTER_START = 2'd2;

	localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_EDGE = 24'h800000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_SAT  = 24'h800001;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_LENGTH = 2'd1,
		ERR_CRC    = 2'd2,
		ERR_HEADER = 2'd3
	} err_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WORD_SIZE = 2'd0,
		REG_CHANNELS  = 2'd1,
		REG_CRC_EN    = 2'd2,
		REG_SPIKE_THR = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_CHECK,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic take_byte;
		logic eval;
		logic load_err;
		logic load_sample;
		logic finish;
		logic finish_good;
	} dp_cmd_t;

	typedef struct packed {
		logic err_found;
		logic ch_last;
		logic out_free;
	} dp_stat_t;

endpackage

[src/afd_if.sv]
interface afd_byte_if;
	import afd_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

interface afd_result_if;
	import afd_pkg::*;

	logic                       valid;
	logic                       ready;
	err_code_t                  error_code;
	logic [CH_W-1:0]            channel_index;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic [STATUS_W-1:0]        status_word;
	logic                       last;

	modport source (output valid, output error_code, output channel_index,
		output sample_value, output status_word, output last, input ready);
	modport sink   (input valid, input error_code, input channel_index,
		input sample_value, input status_word, input last, output ready);
endinterface

[src/afd_ctrl.sv]
`include "assert_macros.svh"

module afd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_end,
	output logic             in_ready,
	input  afd_pkg::dp_stat_t stat,
	output afd_pkg::dp_cmd_t  cmd
);
	import afd_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_COLLECT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					if (in_end) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				cmd.eval = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					if (stat.err_found) begin
						cmd.load_err = 1'b1;
						cmd.finish   = 1'b1;
						state_d      = ST_COLLECT;
					end else begin
						cmd.load_sample = 1'b1;
						if (stat.ch_last) begin
							cmd.finish      = 1'b1;
							cmd.finish_good = 1'b1;
							state_d         = ST_COLLECT;
						end
					end
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	`AFD_ASSERT_NXT(a_end_goes_to_check, cmd.take_byte && in_end, state_q == ST_CHECK,
		"frame end byte did not lead to the check cycle")
	`AFD_ASSERT_IMP(a_one_result_kind, 1'b1, !(cmd.load_err && cmd.load_sample),
		"error and sample results loaded together")
	`AFD_ASSERT_IMP(a_good_finish_with_sample, cmd.finish_good,
		cmd.load_sample && cmd.finish, "good frame closed without its final sample")

endmodule

[src/afd_dp.sv]
`include "assert_macros.svh"

module afd_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [afd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [afd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [7:0]                         data_byte,
	input  afd_pkg::dp_cmd_t                   cmd,
	output afd_pkg::dp_stat_t                  stat,
	input  logic                               out_ready,
	output logic                               out_valid,
	output afd_pkg::err_code_t                 error_code,
	output logic [afd_pkg::CH_W-1:0]           channel_index,
	output logic signed [afd_pkg::SAMPLE_W-1:0] sample_value,
	output logic [afd_pkg::STATUS_W-1:0]       status_word,
	output logic                               last
);
	import afd_pkg::*;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [SAMPLE_W-1:0] decode_word(input logic [31:0] raw,
			input logic [2:0] wb);
		logic [SAMPLE_W-1:0] t;
		unique case (wb)
			WB_16:   t = {raw[15:0], 8'h00};
			WB_24:   t = raw[23:0];
			default: t = raw[31:8] + {23'd0, raw[31] & (raw[7:0] != 8'h00)};
		endcase
		if (t == SAMPLE_NEG_EDGE) begin
			t = SAMPLE_NEG_SAT;
		end
		return t;
	endfunction

	// Configuration registers.
	logic [2:0]          wsb_q;
	logic [3:0]          nch_q;
	logic                crc_en_q;
	logic [23:0]         thr_q;

	// Frame state.
	logic [5:0]          pos_q;
	logic [1:0]          in_word_q;
	logic [4:0]          widx_q;
	logic [31:0]         word_q;
	logic [15:0]         crc_q;
	logic [15:0]         rx_crc_q;
	logic [STATUS_W-1:0] status_q;
	err_code_t           err_q;
	logic [CH_W-1:0]     ch_q;
	logic [1:0]          good_seen_q;

	logic [SAMPLE_W-1:0] cs_q [MAX_CHANNELS];
	logic [SAMPLE_W-1:0] lg_q [MAX_CHANNELS];

	// Output register.
	logic                ov_q;
	err_code_t           oerr_q;
	logic [CH_W-1:0]     och_q;
	logic [SAMPLE_W-1:0] osmp_q;
	logic [STATUS_W-1:0] ostat_q;
	logic                olast_q;

	logic [2:0]          wb_eff;
	logic [CH_CNT_W-1:0] nch_eff;
	logic [3:0]          words_payload;
	logic [3:0]          words_total;
	logic [6:0]          payload_bytes;
	logic [6:0]          total_len;
	logic [1:0]          wb_m1;
	logic                word_done;
	logic [31:0]         word_next;
	logic [31:0]         raw_word;
	logic [SAMPLE_W-1:0] decoded;
	logic [7:0]          hdr_byte;
	logic [CH_W-1:0]     ch_final;
	logic [SAMPLE_W-1:0] cur_smp;
	logic [SAMPLE_W-1:0] prev_smp;
	logic [SAMPLE_W:0]   diff;
	logic [SAMPLE_W:0]   mag;
	logic                spike;
	logic [SAMPLE_W-1:0] filt;

	always_comb begin
		if (wsb_q < WB_16) begin
			wb_eff = WB_16;
		end else if (wsb_q > WB_32) begin
			wb_eff = WB_32;
		end else begin
			wb_eff = wsb_q;
		end
		if (nch_q == 4'd0) begin
			nch_eff = 4'd1;
		end else if (nch_q > CH_CNT_W'(MAX_CHANNELS)) begin
			nch_eff = CH_CNT_W'(MAX_CHANNELS);
		end else begin
			nch_eff = nch_q;
		end
	end

	assign words_payload = 4'd1 + nch_eff;
	assign words_total   = words_payload + {3'd0, crc_en_q};
	assign payload_bytes = 7'(words_payload) * 7'(wb_eff);
	assign total_len     = 7'(words_total) * 7'(wb_eff);
	assign wb_m1         = 2'(wb_eff - 3'd1);
	assign word_done     = (in_word_q == wb_m1);
	assign word_next     = (in_word_q == 2'd0) ? {24'h000000, data_byte}
	                                          : {word_q[23:0], data_byte};
	assign decoded       = decode_word(word_next, wb_eff);
	assign ch_final      = CH_W'(nch_eff - 4'd1);

	always_comb begin
		unique case (wb_eff)
			WB_16: begin
				raw_word = {16'h0000, word_next[15:0]};
				hdr_byte = status_q[15:8];
			end
			WB_24: begin
				raw_word = {8'h00, word_next[23:0]};
				hdr_byte = status_q[23:16];
			end
			default: begin
				raw_word = word_next;
				hdr_byte = status_q[31:24];
			end
		endcase
	end

	// Spike filter for the channel being emitted.
	assign cur_smp  = cs_q[ch_q];
	assign prev_smp = lg_q[ch_q];
	assign diff     = {cur_smp[SAMPLE_W-1], cur_smp} - {prev_smp[SAMPLE_W-1], prev_smp};
	assign mag      = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
	assign spike    = (good_seen_q >= GOOD_FILTER_START) && (mag > {1'b0, thr_q});
	assign filt     = spike ? prev_smp : cur_smp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsb_q    <= WORD_SIZE_RESET;
			nch_q    <= CHANNELS_RESET;
			crc_en_q <= CRC_EN_RESET;
			thr_q    <= SPIKE_THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WORD_SIZE: wsb_q    <= cfg_wdata[2:0];
				REG_CHANNELS:  nch_q    <= cfg_wdata[3:0];
				REG_CRC_EN:    crc_en_q <= cfg_wdata[0];
				REG_SPIKE_THR: thr_q    <= cfg_wdata[23:0];
				default:       thr_q    <= thr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			in_word_q   <= '0;
			widx_q      <= '0;
			word_q      <= '0;
			crc_q       <= CRC_INIT;
			rx_crc_q    <= '0;
			status_q    <= '0;
			err_q       <= ERR_NONE;
			ch_q        <= '0;
			good_seen_q <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				lg_q[i] <= '0;
			end
		end else begin
			if (cmd.take_byte) begin
				word_q <= word_next;
				if ({1'b0, pos_q} < payload_bytes) begin
					crc_q <= crc_byte(crc_q, data_byte);
				end else if (crc_en_q && ({1'b0, pos_q} < total_len)) begin
					rx_crc_q <= {rx_crc_q[7:0], data_byte};
				end
				if (word_done && (widx_q == 5'd0)) begin
					status_q <= raw_word;
				end
				// Once the count has saturated the word counters hold still as well.
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 6'd1;
					if (word_done) begin
						in_word_q <= 2'd0;
						widx_q    <= widx_q + 5'd1;
					end else begin
						in_word_q <= in_word_q + 2'd1;
					end
				end
			end
			if (cmd.eval) begin
				if ({1'b0, pos_q} != total_len) begin
					err_q <= ERR_LENGTH;
				end else if (crc_en_q && (crc_q != rx_crc_q)) begin
					err_q <= ERR_CRC;
				end else if (hdr_byte != HDR_MARK) begin
					err_q <= ERR_HEADER;
				end else begin
					err_q <= ERR_NONE;
				end
			end
			if (cmd.load_sample) begin
				// The channel being emitted takes its filtered value; on the final
				// sample of a good frame the channels beyond the count are cleared.
				for (int i = 0; i < MAX_CHANNELS; i++) begin
					if (CH_W'(i) == ch_q) begin
						lg_q[i] <= filt;
					end else if (cmd.finish_good && (CH_CNT_W'(i) >= nch_eff)) begin
						lg_q[i] <= '0;
					end
				end
				if (!cmd.finish) begin
					ch_q <= ch_q + 3'd1;
				end
			end
			if (cmd.finish_good) begin
				if (good_seen_q < GOOD_FILTER_START) begin
					good_seen_q <= good_seen_q + 2'd1;
				end
			end
			if (cmd.finish) begin
				pos_q     <= '0;
				in_word_q <= '0;
				widx_q    <= '0;
				word_q    <= '0;
				crc_q     <= CRC_INIT;
				rx_crc_q  <= '0;
				status_q  <= '0;
				ch_q      <= '0;
			end
		end
	end

	// Channel sample store: written as each channel word completes.
	always_ff @(posedge clk) begin
		if (cmd.take_byte && word_done && (widx_q != 5'd0) && ({1'b0, widx_q} <= 6'(nch_eff)))
		begin
			cs_q[CH_W'(widx_q - 5'd1)] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load_err || cmd.load_sample) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_err) begin
			oerr_q  <= err_q;
			och_q   <= '0;
			osmp_q  <= '0;
			ostat_q <= status_q;
			olast_q <= 1'b1;
		end else if (cmd.load_sample) begin
			oerr_q  <= ERR_NONE;
			och_q   <= ch_q;
			osmp_q  <= filt;
			ostat_q <= status_q;
			olast_q <= (ch_q == ch_final);
		end
	end

	assign out_valid     = ov_q;
	assign error_code    = oerr_q;
	assign channel_index = och_q;
	assign sample_value  = osmp_q;
	assign status_word   = ostat_q;
	assign last          = olast_q;

	assign stat.err_found = (err_q != ERR_NONE);
	assign stat.ch_last   = (ch_q == ch_final);
	assign stat.out_free  = !ov_q || out_ready;

	`AFD_ASSERT_IMP(a_load_only_when_free, cmd.load_err || cmd.load_sample,
		!ov_q || out_ready, "result loaded over one still waiting")
	`AFD_ASSERT_IMP(a_word_phase_in_range, 1'b1, in_word_q <= wb_m1,
		"byte phase beyond the word size")
	`AFD_ASSERT_IMP(a_error_result_shape, ov_q && (oerr_q != ERR_NONE),
		olast_q && (och_q == '0) && (osmp_q == '0), "malformed error result")

endmodule

[src/adc_frame_deframer_spike_filter.sv]
// Channel    Direction  Handshake      Carries
// byte_in    in         valid/ready    data_byte, frame_end
// result     out        valid/ready    error_code, channel_index, sample_value,
//                                      status_word, last
// cfg        in         cfg_we only    cfg_index, cfg_wdata
//
// A byte that is not the last of its frame is taken at once, back to back.
// A frame-end byte is followed by the check state and then the emit state, which
// loads one result per cycle while the output register is free (one result for a
// failed frame, one per channel for a good one); byte_in.ready is low over that span.
// The emit loop runs over the channel store, one entry per result.
// Reset is asynchronous: the frame state, the last-good store and the
// configuration registers go to their defaults at once.
// A low result.ready holds the waiting item in the output register and freezes
// the emit loop until it is taken.

module adc_frame_deframer_spike_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	afd_byte_if.sink                       byte_in,
	afd_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [afd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [afd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import afd_pkg::*;

	// Commands from the sequencer to the datapath and status back.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller owns the frame sequence: it takes bytes, triggers the
	// frame check once the last byte is in, and paces the results against the
	// free state of the output register.
	afd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_in.valid),
		.in_end   (byte_in.frame_end),
		.in_ready (byte_in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the configuration, assembles words, runs the CRC,
	// decodes and stores the channel samples, applies the spike filter and
	// keeps the output register.
	afd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.data_byte     (byte_in.data_byte),
		.cmd           (cmd),
		.stat          (stat),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.error_code    (result.error_code),
		.channel_index (result.channel_index),
		.sample_value  (result.sample_value),
		.status_word   (result.status_word),
		.last          (result.last)
	);

endmodule

[tb/afd_frame_checker.sv]
module afd_frame_checker
	import afd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	afd_byte_if                   byte_mon,
	afd_result_if                 res_mon,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending,
	output int                    samples_seen,
	output int                    errors_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint SAMPLE_LIMIT = 64'sd8388607;

	typedef struct {
		err_code_t                  err;
		logic [CH_W-1:0]            chan;
		logic signed [SAMPLE_W-1:0] sample;
		logic [STATUS_W-1:0]        status;
		logic                       last;
	} frame_result_t;

	frame_result_t results_due[$];

	// Register mirror, updated from the write port.
	logic [2:0]          word_size_reg;
	logic [CH_CNT_W-1:0] chan_count_reg;
	logic                crc_on_reg;
	logic [23:0]         spike_limit;

	// Deframer state.
	logic [5:0]                 byte_pos;
	logic [31:0]                word_acc;
	logic [15:0]                crc_run;
	logic [15:0]                crc_rx;
	logic [31:0]                status_acc;
	logic signed [SAMPLE_W-1:0] chan_sample [MAX_CHANNELS];
	logic signed [SAMPLE_W-1:0] prev_good [MAX_CHANNELS];
	logic [1:0]                 good_frames;

	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		return c;
	endfunction

	// Sign extend the word, bring it to 24-bit scale and clip symmetrically.
	function automatic logic signed [SAMPLE_W-1:0] scale_word(input logic [31:0] raw,
			input int unsigned wb);
		longint v;
		case (wb)
			2: v = longint'($signed(raw[15:0])) * 256;
			3: v = longint'($signed(raw[23:0]));
			default: v = longint'($signed(raw)) / 256;
		endcase
		if (v > SAMPLE_LIMIT)
			v = SAMPLE_LIMIT;
		if (v < -SAMPLE_LIMIT)
			v = -SAMPLE_LIMIT;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic clear_frame();
		byte_pos   = '0;
		word_acc   = '0;
		crc_run    = CRC_INIT;
		crc_rx     = '0;
		status_acc = '0;
	endtask

	task automatic take_byte(input logic [7:0] b, input logic fe);
		int unsigned wb, nch, frame_len, payload_bytes, pos, in_word, widx;
		logic [31:0] mask, raw, hdr_word;
		logic signed [SAMPLE_W-1:0] v;
		longint diff;
		frame_result_t r;

		wb = (word_size_reg < 2) ? 2 : (word_size_reg > 4) ? 4 : word_size_reg;
		nch = (chan_count_reg == 0) ? 1 :
			(chan_count_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_count_reg;
		frame_len = (1 + nch + crc_on_reg) * wb;
		payload_bytes = (1 + nch) * wb;
		pos = byte_pos;
		in_word = pos % wb;
		widx = pos / wb;
		mask = (wb == 4) ? 32'hFFFF_FFFF : ((32'd1 << (wb * 8)) - 32'd1);

		word_acc = (in_word == 0) ? {24'd0, b} : {word_acc[23:0], b};
		if (pos < payload_bytes)
			crc_run = crc16_update(crc_run, b);
		else if (crc_on_reg && pos < frame_len)
			crc_rx = {crc_rx[7:0], b};

		if (in_word == wb - 1) begin
			raw = word_acc & mask;
			if (widx == 0)
				status_acc = raw;
			else if (widx <= nch)
				chan_sample[widx - 1] = scale_word(raw, wb);
		end

		if (!fe) begin
			if (byte_pos != POS_MAX)
				byte_pos++;
			return;
		end

		r.err = ERR_NONE;
		r.chan = '0;
		r.sample = '0;
		r.status = status_acc;
		r.last = 1'b1;
		hdr_word = status_acc >> (wb * 8 - 8);

		if (pos + 1 != frame_len) begin
			r.err = ERR_LENGTH;
			results_due.push_back(r);
		end else if (crc_on_reg && crc_run != crc_rx) begin
			r.err = ERR_CRC;
			results_due.push_back(r);
		end else if (hdr_word[7:0] != HDR_MARK) begin
			r.err = ERR_HEADER;
			results_due.push_back(r);
		end else begin
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				if (ch < nch) begin
					v = chan_sample[ch];
					// The spike filter only acts once two good frames have been seen.
					if (good_frames >= GOOD_FILTER_START) begin
						diff = longint'(v) - longint'(prev_good[ch]);
						if (diff < 0)
							diff = -diff;
						if (diff > longint'(spike_limit))
							v = prev_good[ch];
					end
					prev_good[ch] = v;
					r.chan = 3'(ch);
					r.sample = v;
					r.last = (ch + 1 == nch);
					results_due.push_back(r);
				end else begin
					prev_good[ch] = '0;
				end
			end
			if (good_frames < GOOD_FILTER_START)
				good_frames++;
		end
		clear_frame();
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		fail_count++;
		$display("%0t: mismatch on %s, expected %h, got %h", $time, what, want, got);
	endtask

	task automatic check_result();
		frame_result_t want;
		if (results_due.size() == 0) begin
			report_mismatch("result with none expected", '0, 32'(res_mon.error_code));
			return;
		end
		want = results_due.pop_front();
		if (res_mon.error_code !== want.err)
			report_mismatch("error_code", 32'(want.err), 32'(res_mon.error_code));
		if (res_mon.channel_index !== want.chan)
			report_mismatch("channel_index", 32'(want.chan), 32'(res_mon.channel_index));
		if (res_mon.sample_value !== want.sample)
			report_mismatch("sample_value", 32'(want.sample), 32'(res_mon.sample_value));
		if (res_mon.status_word !== want.status)
			report_mismatch("status_word", want.status, res_mon.status_word);
		if (res_mon.last !== want.last)
			report_mismatch("last", 32'(want.last), 32'(res_mon.last));
		if (want.err == ERR_NONE)
			samples_seen++;
		else
			errors_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_size_reg  = WORD_SIZE_RESET;
			chan_count_reg = CHANNELS_RESET;
			crc_on_reg     = CRC_EN_RESET;
			spike_limit    = SPIKE_THR_RESET;
			clear_frame();
			foreach (chan_sample[i]) begin
				chan_sample[i] = '0;
				prev_good[i] = '0;
			end
			good_frames = '0;
			results_due.delete();
			fail_count = 0;
			pending = 0;
			samples_seen = 0;
			errors_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_WORD_SIZE: word_size_reg  = cfg_wdata[2:0];
					REG_CHANNELS:  chan_count_reg = cfg_wdata[CH_CNT_W-1:0];
					REG_CRC_EN:    crc_on_reg     = cfg_wdata[0];
					REG_SPIKE_THR: spike_limit    = cfg_wdata[23:0];
					default: ;
				endcase
			end
			if (byte_mon.valid && byte_mon.ready)
				take_byte(byte_mon.data_byte, byte_mon.frame_end);
			if (res_mon.valid && res_mon.ready)
				check_result();
			pending = results_due.size();
		end
	end

endmodule

[tb/adc_frame_deframer_spike_filter_tb.sv]
module adc_frame_deframer_spike_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import afd_pkg::*;

	// Each random phase runs until roughly this many bytes have gone in.
	localparam int PHASE_BYTES     = 35;
	// Cycles without any handshake before the run is declared hung. The longest
	// legitimate quiet spell is the receiver hold-off plus a settling pause.
	localparam int WATCHDOG_LIMIT  = 2000;
	// Long receiver hold-off, long enough for the block to back up completely.
	localparam int HOLD_OFF_CYCLES = 300;
	// Settling pause, with room for the check state and the emit loop after a frame end.
	localparam int SETTLE_CYCLES   = 16;

	typedef enum int {
		FK_GOOD,
		FK_BAD_HEADER,
		FK_BAD_CRC,
		FK_SHORT,
		FK_LONG,
		FK_JUNK
	} frame_kind_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	cfg_reg_t              cfg_index = REG_WORD_SIZE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int fail_count;
	int results_pending;
	int samples_seen;
	int errors_seen;

	// Stimulus bookkeeping.
	int   bytes_sent    = 0;
	int   frames_sent   = 0;
	int   settings_used = 0;
	logic idling_on     = 1'b0;
	logic hold_off_req  = 1'b0;
	logic hold_off_done = 1'b0;

	// What the stimulus believes the registers hold, clamped the way the block
	// interprets them, so that well-formed frames have the right shape.
	logic crc_reg = CRC_EN_RESET;
	int   eff_wb  = 3;
	int   eff_nch = 8;

	// Recent raw word per channel; most new words sit close to it so that the
	// spike filter sees a realistic mix of small steps and real spikes.
	logic [31:0] chan_base [MAX_CHANNELS];
	logic [7:0]  frame_buf[$];

	afd_byte_if   byte_in ();
	afd_result_if result ();

	adc_frame_deframer_spike_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	afd_frame_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_mon     (byte_in),
		.res_mon      (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.pending      (results_pending),
		.samples_seen (samples_seen),
		.errors_seen  (errors_seen)
	);

	always #1 clk = ~clk;

	// Register write: one cycle with the enable high. The task opens on a fresh
	// falling edge so that back-to-back writes never lower and raise the enable
	// in the same time step.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic apply_setting(input logic [2:0] ws, input logic [3:0] nch,
			input logic crc_en, input logic [23:0] thr);
		write_reg(REG_WORD_SIZE, CFG_DATA_W'(ws));
		write_reg(REG_CHANNELS, CFG_DATA_W'(nch));
		write_reg(REG_CRC_EN, CFG_DATA_W'(crc_en));
		write_reg(REG_SPIKE_THR, thr);
		crc_reg = crc_en;
		eff_wb = (ws < 2) ? 2 : (ws > 4) ? 4 : int'(ws);
		eff_nch = (nch == 0) ? 1 : (nch > MAX_CHANNELS) ? MAX_CHANNELS : int'(nch);
		settings_used++;
	endtask

	// Offers one byte and returns on the falling edge after it has been taken.
	// Valid is left high so that the next byte can follow without a gap; the
	// random gap, when there is one, lowers it first.
	task automatic send_byte(input logic [7:0] b, input logic fe);
		if (idling_on && $urandom_range(0, 5) == 0) begin
			byte_in.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		byte_in.valid     <= 1'b1;
		byte_in.data_byte <= b;
		byte_in.frame_end <= fe;
		do @(posedge clk); while (!byte_in.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	// Stop offering, let every expected result come out, then allow the block
	// to settle before anything touches the registers.
	task automatic wait_idle();
		byte_in.valid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic void put_word(input logic [31:0] w);
		for (int i = eff_wb - 1; i >= 0; i--)
			frame_buf.push_back(w[8*i +: 8]);
	endfunction

	function automatic logic [15:0] ccitt_crc(input int count);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = 0; i < count; i++) begin
			c ^= {frame_buf[i], 8'h00};
			repeat (8) c = {c[14:0], 1'b0} ^ (c[15] ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	// Builds one frame for the current setting. Well-formed frames carry a
	// valid header and, with CRC on, a valid CRC; junk is random bytes, the rest break one thing at most.
	function automatic void build_frame(input frame_kind_t kind);
		logic [31:0] status;
		logic [31:0] word;
		logic [7:0]  hdr;
		logic [15:0] crc;
		int          d;
		int          cut;
		int          flip;
		int unsigned pick;

		frame_buf.delete();
		if (kind == FK_JUNK) begin
			repeat ($urandom_range(1, 10)) frame_buf.push_back(8'($urandom()));
			return;
		end

		status = $urandom();
		hdr = HDR_MARK;
		if (kind == FK_BAD_HEADER) begin
			hdr = 8'($urandom_range(0, 254));
			if (hdr >= HDR_MARK)
				hdr++;
		end
		status[8*(eff_wb-1) +: 8] = hdr;
		put_word(status);

		for (int ch = 0; ch < eff_nch; ch++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// A small step, scaled so that it stays well under the default
				// threshold whatever the word size.
				d = int'($urandom_range(0, 2048)) - 1024;
				word = chan_base[ch] + 32'(d <<< (8 * (eff_wb - 2)));
			end else if (pick < 70) begin
				word = $urandom();
			end else if (pick < 80) begin
				word = 32'h7FFF_FFFF >> (8 * (4 - eff_wb));
			end else if (pick < 90) begin
				word = 32'h8000_0000 >> (8 * (4 - eff_wb));
			end else if (pick < 95) begin
				word = '1;
			end else begin
				word = chan_base[ch];
			end
			chan_base[ch] = word;
			put_word(word);
		end

		if (crc_reg) begin
			crc = ccitt_crc(frame_buf.size());
			word = $urandom();
			word[15:0] = crc;
			if (kind == FK_BAD_CRC) begin
				flip = $urandom_range(0, 15);
				word[flip] = ~word[flip];
			end
			put_word(word);
		end

		if (kind == FK_SHORT) begin
			cut = $urandom_range(1, frame_buf.size() - 1);
			while (frame_buf.size() > cut)
				void'(frame_buf.pop_back());
		end else if (kind == FK_LONG) begin
			repeat ($urandom_range(1, 4)) frame_buf.push_back(8'($urandom()));
		end
	endfunction

	// Fixed one-channel, 16-bit frame with CRC, for the opening directed cases.
	task automatic compose_frame(input logic [15:0] status, input logic [15:0] sample,
			input logic [15:0] crc_xor);
		logic [15:0] crc;
		frame_buf.delete();
		put_word({16'd0, status});
		put_word({16'd0, sample});
		crc = ccitt_crc(frame_buf.size()) ^ crc_xor;
		put_word({16'd0, crc});
		send_frame();
	endtask

	// Receiver. It normally takes results at once, idles in random bursts when
	// idling is on, and, once asked, holds off for a long stretch so that the
	// result register fills, the emit loop freezes and byte_in stalls.
	initial begin
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				result.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_done = 1'b1;
				result.ready <= 1'b1;
			end else if (idling_on && $urandom_range(0, 4) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// Watchdog: any accepted item on either channel restarts the count.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((byte_in.valid && byte_in.ready) || (result.valid && result.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Watchdog expired after %0d cycles with no handshake", WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int          budget;
		frame_kind_t kind;
		int unsigned pick;

		byte_in.valid     = 1'b0;
		byte_in.data_byte = '0;
		byte_in.frame_end = 1'b0;
		foreach (chan_base[i])
			chan_base[i] = $urandom();

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed opening: short 16-bit frames with one channel and a CRC, so
		// that the codes at both ends, a truncated frame, a corrupted CRC and a
		// wrong header all fit in a couple of dozen bytes.
		apply_setting(WB_16, 4'd1, 1'b1, SPIKE_THR_RESET);
		idling_on = 1'b1;
		// Largest positive code, then the most negative code, which has to clip.
		compose_frame(16'h05A5, 16'h7FFF, 16'h0000);
		compose_frame(16'h05FF, 16'h8000, 16'h0000);
		// A lone byte that also ends the frame gives a length error.
		frame_buf = '{8'hFF};
		send_frame();
		// Right length and header, but the CRC is one bit off.
		compose_frame(16'h0500, 16'h0000, 16'h0001);
		// Correct CRC over a status word whose top byte is not the marker.
		compose_frame(16'h0600, 16'h1234, 16'h0000);
		wait_idle();

		// Random phases. Each one writes every register, then streams mostly
		// well-formed frames with random content plus a share of broken ones.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: apply_setting(WB_24, 4'd8, 1'b0, SPIKE_THR_RESET);
				1: apply_setting(WB_32, 4'd3, 1'b1, 24'd0);
				2: apply_setting(WB_16, 4'd8, 1'b1, 24'hFF_FFFF);
				// Register values below the legal range: one channel, 16-bit words.
				3: apply_setting(3'd0, 4'd0, 1'b0, 24'd1000);
				// Values above it: eight channels, 32-bit words.
				4: apply_setting(3'd7, 4'd15, 1'b1, 24'($urandom_range(0, 24'hFF_FFFF)));
				default: apply_setting(WB_24, 4'($urandom_range(1, 15)), 1'b1,
					24'($urandom_range(0, 24'hFF_FFFF)));
			endcase

			// The third phase is a clean stretch and the final phase runs without any
			// idling at all.
			idling_on = (p != 2) && (p != 5);
			// During the second phase the receiver stops for a long while and
			// the sender keeps going until the block pushes back.
			if (p == 1)
				hold_off_req = 1'b1;

			// One oversized frame drives the byte position into saturation.
			if (p == 0) begin
				frame_buf.delete();
				repeat (66) frame_buf.push_back(8'($urandom()));
				send_frame();
			end

			budget = bytes_sent + PHASE_BYTES;
			while (bytes_sent < budget) begin
				pick = $urandom_range(0, 99);
				if (pick < 68)
					kind = FK_GOOD;
				else if (pick < 75)
					kind = FK_BAD_HEADER;
				else if (pick < 82)
					kind = FK_BAD_CRC;
				else if (pick < 88)
					kind = FK_SHORT;
				else if (pick < 94)
					kind = FK_LONG;
				else
					kind = FK_JUNK;
				build_frame(kind);
				send_frame();
			end
			wait_idle();
		end

		$display("Run covered %0d bytes in %0d frames under %0d register settings,",
			bytes_sent, frames_sent, settings_used);
		$display("including out-of-range sizes, a long stall; %0d samples, %0d error results",
			samples_seen, errors_seen);
		if (fail_count == 0 && results_pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
